// ----- src/sha256_message_hasher_assert.svh -----
// assertion macros for the message hasher
`ifndef SHA256_MESSAGE_HASHER_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_ASSERT_SVH

// implication checked on every edge outside reset
`define SHA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/sha_pkg.sv -----
package sha_pkg;

  localparam logic [1:0] OP_BYTE   = 2'd0;
  localparam logic [1:0] OP_LAST   = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  typedef logic [31:0] word_t;

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    case (t)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_hash(input logic [2:0] i);
    word_t h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // status from the compression core back to the front end
  typedef struct packed {
    logic start;
    logic busy;
  } core_ctl_t;

endpackage

// ----- src/sha256_message_hasher.sv -----
// channel  | handshake      | payload
// in       | in_valid/stall | opcode, data_byte
// out      | out_valid/stall| digest_word, word_index, last_word
// a byte is taken while in_stall is low; every 64th byte starts a block compression
// (one round per cycle through the working registers)
// finish pads byte by byte (up to 64+8 pad bytes, two blocks), then 8 outputs
// rst is synchronous and returns the chaining hash to the initial values
// in_stall is high while padding, compressing, sending the digest or reinitialising the hash
module sha256_message_hasher
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WAIT = 5'b00010,
    S_PAD  = 5'b00100,
    S_OUT  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t      state;
  state_t      ret;
  logic [5:0]  fill;
  logic [63:0] bits;
  logic [23:0] acc;
  logic        wr_en;
  logic [3:0]  wr_addr;
  word_t       wr_data;
  logic        push;
  logic [7:0]  push_byte;
  logic        start;
  logic        init;
  logic        take;
  logic        out_take;
  logic        fin_req;
  core_ctl_t   ctl;
  word_t       hword;
  logic [7:0]  pad_byte;
  logic        pad_first;
  logic        pad_zero;

  assign take = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign in_stall = (state != S_IDLE);

  // padding byte for the current fill position
  // zeros before byte 56, and past it only while finishing the block that took the 0x80 at or past byte 56
  always_comb begin
    if (fill >= 6'd56 && !pad_zero) begin
      pad_byte = bits[{~fill[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    push = 1'b0;
    push_byte = data_byte;
    if (state == S_IDLE && take && (opcode == OP_BYTE || opcode == OP_LAST)) begin
      push = 1'b1;
    end else if (state == S_PAD) begin
      push = 1'b1;
      push_byte = pad_first ? 8'h80 : pad_byte;
    end
  end

  assign wr_en = push && (fill[1:0] == 2'd3);
  assign wr_addr = fill[5:2];
  assign wr_data = {acc, push_byte};
  assign start = push && (fill == 6'd63);
  assign init = (state == S_DONE);

  sha_core u_core (
    .clk(clk), .rst(rst), .start(start), .init(init),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .hrd_idx(word_index), .hrd_data(hword), .ctl(ctl)
  );

  assign digest_word = hword;
  assign out_valid = (state == S_OUT);
  assign last_word = (word_index == 3'd7);

  assign fin_req = take && (opcode == OP_LAST || opcode == OP_FINISH);

  // byte packing, fill and length
  always_ff @(posedge clk) begin
    if (push) acc <= {acc[15:0], push_byte};
    if (rst || init) begin
      fill <= '0;
      bits <= '0;
    end else begin
      if (push) fill <= fill + 6'd1;
      if (state == S_IDLE && take && (opcode == OP_BYTE || opcode == OP_LAST))
        bits <= bits + 64'd8;
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret <= S_IDLE;
      pad_first <= 1'b0;
      pad_zero <= 1'b0;
      word_index <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          pad_first <= fin_req;
          if (start) begin
            state <= S_WAIT;
            ret <= fin_req ? S_PAD : S_IDLE;
          end else if (fin_req) begin
            state <= S_PAD;
          end
        end
        S_WAIT: if (!ctl.busy && !ctl.start) state <= ret;
        S_PAD: begin
          pad_first <= 1'b0;
          if (start) begin
            state <= S_WAIT;
            pad_zero <= 1'b0;
            ret <= (!pad_first && !pad_zero) ? S_OUT : S_PAD;
          end else if (pad_first && fill >= 6'd56) begin
            pad_zero <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_take) begin
            word_index <= word_index + 3'd1;
            if (word_index == 3'd7) state <= S_DONE;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`include "sha256_message_hasher_assert.svh"

  `SHA_ASSERT_IMPL(a_no_take_busy, ctl.busy, in_stall, "input taken during compression")
  `SHA_ASSERT_IMPL(a_out_idle_core, out_valid, !ctl.busy, "digest sent while compressing")
  `SHA_ASSERT_NEXT(a_last_done, out_take && last_word, state == S_DONE, "no restart after digest")

endmodule

// ----- src/sha_core.sv -----
module sha_core
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        init,
  // message word port into the schedule memory (one word per 4 bytes)
  input  logic        wr_en,
  input  logic [3:0]  wr_addr,
  input  word_t       wr_data,
  input  logic [2:0]  hrd_idx,
  output word_t       hrd_data,
  output core_ctl_t   ctl
);

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_LOAD = 4'b0010,
    C_RUN  = 4'b0100,
    C_ADD  = 4'b1000
  } cstate_t;

  cstate_t     state;
  logic [5:0]  t;
  word_t       a, b, c, d, e, f, g, h;
  word_t       hash [8];

  // schedule memory: 16 words, read at four addresses, so kept as a window
  word_t       sched [16];

  word_t w_cur, x15, x2, x7, x16, s0, s1, w_new, t1, t2;

  assign x16 = sched[t[3:0]];
  assign x15 = sched[t[3:0] + 4'd1];
  assign x7  = sched[t[3:0] + 4'd9];
  assign x2  = sched[t[3:0] + 4'd14];
  assign s0 = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
  assign s1 = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
  assign w_new = x16 + s0 + x7 + s1;
  assign w_cur = (t < 6'd16) ? x16 : w_new;

  assign t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
              + round_k(t) + w_cur;
  assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));

  assign hrd_data = hash[hrd_idx];
  assign ctl.start = start;
  assign ctl.busy = (state != C_IDLE);

  // schedule window writes
  always_ff @(posedge clk) begin
    if (wr_en) begin
      sched[wr_addr] <= wr_data;
    end else if (state == C_RUN && t >= 6'd16) begin
      sched[t[3:0]] <= w_new;
    end
  end

  // round sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      t <= '0;
    end else begin
      unique case (state)
        C_IDLE: if (start) state <= C_LOAD;
        C_LOAD: begin
          t <= '0;
          state <= C_RUN;
        end
        C_RUN: begin
          t <= t + 6'd1;
          if (t == 6'd63) state <= C_ADD;
        end
        C_ADD: state <= C_IDLE;
        default: state <= C_IDLE;
      endcase
    end
  end

  // working variables and chaining hash
  always_ff @(posedge clk) begin
    if (rst || init) begin
      for (int i = 0; i < 8; i++) hash[i] <= init_hash(3'(i));
    end else if (state == C_ADD) begin
      hash[0] <= hash[0] + a; hash[1] <= hash[1] + b;
      hash[2] <= hash[2] + c; hash[3] <= hash[3] + d;
      hash[4] <= hash[4] + e; hash[5] <= hash[5] + f;
      hash[6] <= hash[6] + g; hash[7] <= hash[7] + h;
    end
    if (state == C_LOAD) begin
      a <= hash[0]; b <= hash[1]; c <= hash[2]; d <= hash[3];
      e <= hash[4]; f <= hash[5]; g <= hash[6]; h <= hash[7];
    end else if (state == C_RUN) begin
      h <= g; g <= f; f <= e; e <= d + t1;
      d <= c; c <= b; b <= a; a <= t1 + t2;
    end
  end

endmodule

// ----- verif/tb_sha256_message_hasher.sv -----
`timescale 1ns / 1ps

module tb_sha256_message_hasher;
  import sha_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = OP_BYTE;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] b;
  } byte_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_out_t;

  // hashing state of the predictor
  logic [31:0] hash_state [8];
  logic [7:0]  blk_bytes [64];
  logic [5:0]  blk_fill;
  logic [63:0] bit_count;

  byte_item_t  pending_items [$];
  digest_out_t digest_queue [$];

  int fail_count = 0;
  int digests_seen = 0;
  int words_seen = 0;
  int items_sent = 0;
  int cycle_count = 0;
  logic hold_sender = 1'b0;
  int burst_left = 0;
  int gap_left = 0;

  sha256_message_hasher u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .data_byte(data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void clear_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = init_hash(i[2:0]);
    blk_fill = '0;
    bit_count = '0;
  endfunction

  // one 64-round block compression
  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    for (int j = 0; j < 8; j++) v[j] = hash_state[j];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(t[5:0]) + w[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) hash_state[j] += v[j];
  endfunction

  function automatic void append_byte(input logic [7:0] b);
    blk_bytes[blk_fill] = b;
    blk_fill = blk_fill + 6'd1;
    if (blk_fill == 6'd0) compress_block();
  endfunction

  // predict the digest words caused by one accepted transfer
  function automatic void predict_digest(input byte_item_t it);
    logic [63:0] len;
    digest_out_t d;
    if (it.op == OP_NONE) return;
    if (it.op != OP_FINISH) begin
      append_byte(it.b);
      bit_count += 64'd8;
      if (it.op == OP_BYTE) return;
    end
    len = bit_count;
    append_byte(8'h80);
    while (blk_fill != 6'd56) append_byte(8'h00);
    for (int i = 0; i < 8; i++) append_byte(len[63 - 8*i -: 8]);
    for (int i = 0; i < 8; i++) begin
      d.word = hash_state[i];
      d.idx = i[2:0];
      d.last = (i == 7);
      digest_queue.push_back(d);
    end
    clear_hash();
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h (digest %0d)", what, got, want, digests_seen);
    fail_count++;
  endtask

  task automatic add_message(input int len, input int pattern, input logic [1:0] closing);
    byte_item_t it;
    for (int i = 0; i < len; i++) begin
      it.op = (i == len - 1 && closing == OP_LAST) ? OP_LAST : OP_BYTE;
      case (pattern)
        0: it.b = 8'h00;
        1: it.b = 8'hff;
        default: it.b = 8'($urandom_range(0, 255));
      endcase
      pending_items.push_back(it);
    end
    if (closing == OP_FINISH || len == 0) begin
      it.op = OP_FINISH;
      it.b = 8'($urandom_range(0, 255));
      pending_items.push_back(it);
    end
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) items_sent++;
      if (in_valid) predict_digest('{op: opcode, b: data_byte});
      if (pending_items.size() != 0 && !hold_sender && gap_left == 0) begin
        byte_item_t it;
        it = pending_items.pop_front();
        in_valid <= 1'b1;
        opcode <= it.op;
        data_byte <= it.b;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
        end else begin
          burst_left--;
          if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // receiver stall pattern: alternating calm and choppy stretches
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if ((cycle_count / 400) % 3 == 0) out_stall <= 1'b0;
    else if ((cycle_count / 400) % 3 == 1) out_stall <= ($urandom_range(0, 2) == 0);
    else out_stall <= ($urandom_range(0, 9) < 7);
  end

  // monitor: compare each digest word transfer with the oldest prediction
  always @(posedge clk) begin
    digest_out_t want;
    cycle_count++;
    if (!rst && out_valid && !out_stall) begin
      if (digest_queue.size() == 0) begin
        report_mismatch("unexpected digest_word", digest_word, 32'h0);
      end else begin
        want = digest_queue.pop_front();
        if (digest_word !== want.word) report_mismatch("digest_word", digest_word, want.word);
        if (word_index !== want.idx)
          report_mismatch("word_index", 32'(word_index), 32'(want.idx));
        if (last_word !== want.last)
          report_mismatch("last_word", 32'(last_word), 32'(want.last));
        words_seen++;
        if (want.last) digests_seen++;
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    byte_item_t it;
    int n;
    clear_hash();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty message, extremes, unused opcode, short random messages
    add_message(0, 0, OP_FINISH);
    add_message(1, 0, OP_LAST);
    add_message(1, 1, OP_LAST);
    it.op = OP_NONE; it.b = 8'hff; pending_items.push_back(it);
    add_message(3, 2, OP_FINISH);
    it.op = OP_NONE; it.b = 8'h00; pending_items.push_back(it);
    add_message(2, 2, OP_LAST);
    wait (pending_items.size() == 0 && !in_valid);

    // pause the sender until every digest is back
    hold_sender = 1'b1;
    wait (digest_queue.size() == 0);
    repeat (200) @(posedge clk);
    hold_sender = 1'b0;

    // padding boundaries: 55, 56, 63, 64 bytes
    add_message(55, 2, OP_LAST);
    add_message(56, 2, OP_FINISH);
    add_message(63, 1, OP_LAST);
    add_message(64, 0, OP_FINISH);

    // random messages, mostly short, with stray unused opcodes
    n = items_sent + pending_items.size();
    while (n < 500) begin
      int len;
      if ($urandom_range(0, 9) == 0) begin
        it.op = OP_NONE; it.b = 8'($urandom_range(0, 255));
        pending_items.push_back(it);
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 130) : $urandom_range(0, 20);
      add_message(len, 2, ($urandom_range(0, 1) == 1) ? OP_LAST : OP_FINISH);
      n = items_sent + pending_items.size();
    end

    wait (pending_items.size() == 0 && !in_valid);
    wait (digest_queue.size() == 0);
    repeat (300) @(posedge clk);
    $display("sent %0d transfers, checked %0d digest words in %0d digests",
             items_sent, words_seen, digests_seen);
    if (fail_count == 0 && digest_queue.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/sha_pkg.sv
src/sha_core.sv
src/sha256_message_hasher.sv
verif/tb_sha256_message_hasher.sv
